// ----- rtl/base64_stream_codec_unit_macros.svh -----
// Assertion helpers for the one asserting file, base64_stream_codec_unit.sv.
`ifndef BASE64_STREAM_CODEC_UNIT_MACROS_SVH
`define BASE64_STREAM_CODEC_UNIT_MACROS_SVH

// Condition and consequence in the same cycle.
`define B64SC_ASSERT_SAME(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error(msg);

// Consequence in the cycle after the condition.
`define B64SC_ASSERT_NEXT(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/b64sc_pkg.sv -----
`default_nettype none

package b64sc_pkg;

  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_INVALID = 2'd1;
  localparam logic [1:0] STATUS_BAD_LEN = 2'd2;

  localparam logic [7:0] PAD_CHAR = 8'h3D;
  localparam logic [6:0] NO_INDEX = 7'd64;

  localparam int GROUP_W = 18;

  typedef struct packed {
    logic [3:0][7:0] data;
    logic [1:0]      last_idx;
    logic [1:0]      status;
  } job_t;

  function automatic logic [7:0] sextet_char(logic [5:0] v);
    logic [7:0] w;
    logic [7:0] r;
    w = {2'b00, v};
    if (v < 6'd26) begin
      r = 8'h41 + w;
    end else if (v < 6'd52) begin
      r = 8'h61 + w - 8'd26;
    end else if (v < 6'd62) begin
      r = 8'h30 + w - 8'd52;
    end else if (v == 6'd62) begin
      r = 8'h2B;
    end else begin
      r = 8'h2F;
    end
    return r;
  endfunction

  function automatic logic [6:0] char_index(logic [7:0] c);
    logic [7:0] r;
    r = {1'b0, NO_INDEX};
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c - 8'h41;
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r = c - 8'h61 + 8'd26;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r = c - 8'h30 + 8'd52;
    end else if (c == 8'h2B) begin
      r = 8'd62;
    end else if (c == 8'h2F) begin
      r = 8'd63;
    end
    return r[6:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/b64sc_front.sv -----
`default_nettype none

module b64sc_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_valid,
  input  wire logic             cfg_data,
  input  wire logic             accept,
  input  wire logic [7:0]       in_byte,
  input  wire logic             in_last,
  output logic                  push,
  output b64sc_pkg::job_t       job
);

  logic                             direction;
  logic [b64sc_pkg::GROUP_W-1:0]    group_bits;
  logic [1:0]                       group_count;
  logic                             pad_seen;
  logic                             error_seen;

  logic [b64sc_pkg::GROUP_W-1:0]    group_bits_next;
  logic [1:0]                       group_count_next;
  logic                             pad_seen_next;
  logic                             error_seen_next;
  logic                             emit;

  logic [23:0] enc_word;
  logic [23:0] enc_tail;
  logic [1:0]  enc_count;
  logic [6:0]  raw_idx;
  logic [5:0]  idx;
  logic [23:0] dec_word;
  logic        bad_len;

  always_comb begin
    group_bits_next  = group_bits;
    group_count_next = group_count;
    pad_seen_next    = pad_seen;
    error_seen_next  = error_seen;
    emit             = 1'b0;
    job.data         = '0;
    job.last_idx     = 2'd3;
    job.status       = b64sc_pkg::STATUS_OK;
    enc_word  = {group_bits[15:0], in_byte};
    enc_count = group_count + 2'd1;
    enc_tail  = (enc_count == 2'd2) ? {enc_word[15:0], 8'h00} : {enc_word[7:0], 16'h0000};
    raw_idx   = b64sc_pkg::char_index(in_byte);
    idx       = (raw_idx == b64sc_pkg::NO_INDEX) ? 6'd63 : raw_idx[5:0];
    dec_word  = {group_bits, idx};
    bad_len   = 1'b0;

    if (direction == b64sc_pkg::DIR_ENCODE) begin
      if (enc_count == 2'd3) begin
        emit             = 1'b1;
        job.data[0]      = b64sc_pkg::sextet_char(enc_word[23:18]);
        job.data[1]      = b64sc_pkg::sextet_char(enc_word[17:12]);
        job.data[2]      = b64sc_pkg::sextet_char(enc_word[11:6]);
        job.data[3]      = b64sc_pkg::sextet_char(enc_word[5:0]);
        group_bits_next  = '0;
        group_count_next = 2'd0;
      end else begin
        group_bits_next  = enc_word[b64sc_pkg::GROUP_W-1:0];
        group_count_next = enc_count;
        if (in_last) begin
          emit        = 1'b1;
          job.data[0] = b64sc_pkg::sextet_char(enc_tail[23:18]);
          job.data[1] = b64sc_pkg::sextet_char(enc_tail[17:12]);
          job.data[2] = (enc_count == 2'd2) ? b64sc_pkg::sextet_char(enc_tail[11:6])
                                            : b64sc_pkg::PAD_CHAR;
          job.data[3] = b64sc_pkg::PAD_CHAR;
        end
      end
    end else begin
      if (!pad_seen) begin
        if (in_byte == b64sc_pkg::PAD_CHAR && group_count >= 2'd2) begin
          pad_seen_next = 1'b1;
          emit          = 1'b1;
          if (group_count == 2'd2) begin
            job.data[0]  = group_bits[11:4];
            job.last_idx = 2'd0;
          end else begin
            job.data[0]  = group_bits[17:10];
            job.data[1]  = group_bits[9:2];
            job.last_idx = 2'd1;
          end
          job.status      = {1'b0, error_seen};
          group_bits_next = '0;
        end else begin
          if (raw_idx == b64sc_pkg::NO_INDEX) begin
            error_seen_next = 1'b1;
          end
          group_bits_next = dec_word[b64sc_pkg::GROUP_W-1:0];
          if (group_count == 2'd3) begin
            emit            = 1'b1;
            job.data[0]     = dec_word[23:16];
            job.data[1]     = dec_word[15:8];
            job.data[2]     = dec_word[7:0];
            job.last_idx    = 2'd2;
            job.status      = {1'b0, error_seen_next};
            group_bits_next = '0;
          end
        end
      end
      group_count_next = group_count + 2'd1;
      if (in_last) begin
        bad_len = (group_count_next != 2'd0);
        if (bad_len) begin
          job.status = b64sc_pkg::STATUS_BAD_LEN;
        end
        if (!emit && (bad_len || error_seen_next)) begin
          emit         = 1'b1;
          job.data     = '0;
          job.last_idx = 2'd0;
          job.status   = bad_len ? b64sc_pkg::STATUS_BAD_LEN : b64sc_pkg::STATUS_INVALID;
        end
      end
    end

    if (in_last) begin
      group_bits_next  = '0;
      group_count_next = 2'd0;
      pad_seen_next    = 1'b0;
      error_seen_next  = 1'b0;
    end
  end

  assign push = accept && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      direction   <= b64sc_pkg::DIR_ENCODE;
      group_bits  <= '0;
      group_count <= 2'd0;
      pad_seen    <= 1'b0;
      error_seen  <= 1'b0;
    end else if (cfg_valid) begin
      direction   <= cfg_data;
      group_bits  <= '0;
      group_count <= 2'd0;
      pad_seen    <= 1'b0;
      error_seen  <= 1'b0;
    end else if (accept) begin
      group_bits  <= group_bits_next;
      group_count <= group_count_next;
      pad_seen    <= pad_seen_next;
      error_seen  <= error_seen_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/b64sc_queue.sv -----
`default_nettype none

module b64sc_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire b64sc_pkg::job_t push_job,
  input  wire logic            pop,
  output b64sc_pkg::job_t      head_job,
  output logic                 not_empty,
  output logic                 full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  b64sc_pkg::job_t     slots [DEPTH];
  logic [PTR_W-1:0]    wr_ptr;
  logic [PTR_W-1:0]    rd_ptr;
  logic [CNT_W-1:0]    level;

  assign not_empty = (level != '0);
  assign full      = (level == FULL_CNT);
  assign head_job  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        level <= level + 1'b1;
      end else if (pop && !push) begin
        level <= level - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/b64sc_back.sv -----
`default_nettype none

module b64sc_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire b64sc_pkg::job_t head_job,
  input  wire logic            head_valid,
  output logic                 pop,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [7:0]           out_byte,
  output logic                 out_last,
  output logic [1:0]           out_status
);

  b64sc_pkg::job_t job;
  logic            busy;
  logic [1:0]      idx;
  logic            done;

  assign out_valid  = busy;
  assign out_byte   = job.data[idx];
  assign out_last   = (idx == job.last_idx);
  assign out_status = job.status;
  assign done       = busy && out_ready && out_last;
  assign pop        = head_valid && (!busy || done);

  always_ff @(posedge clk) begin
    if (pop) begin
      job <= head_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 2'd0;
    end else if (pop) begin
      busy <= 1'b1;
      idx  <= 2'd0;
    end else if (done) begin
      busy <= 1'b0;
      idx  <= 2'd0;
    end else if (busy && out_ready) begin
      idx <= idx + 2'd1;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/base64_stream_codec_unit.sv -----
// Streaming Base64 codec. The direction register (cfg_data, written through
// cfg_valid, always ready) selects encoding of raw bytes or decoding of Base64
// characters, and each write also clears the stream state. An input item is
// taken whenever the result queue has room, and the back end sends one result
// item per cycle while out_tready is high, from the head of that queue.
// Encoding a full group turns three input items into four results, so a steady
// encode stream is limited by the single-result output port; a decode stream
// runs at one input item per cycle while the output is not stalled, the rate of
// the input port. The end of a stream is marked by in_tlast on its final item.
`default_nettype none
`include "base64_stream_codec_unit_macros.svh"

module base64_stream_codec_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_data,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] in_byte
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // [7:0] out_byte
  output logic             out_tlast,
  output logic [1:0]       out_tuser   // [1:0] status
);

  b64sc_pkg::job_t push_job;
  b64sc_pkg::job_t head_job;
  logic            push;
  logic            pop;
  logic            q_valid;
  logic            q_full;
  logic            accept;

  assign cfg_ready = 1'b1;
  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  b64sc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .in_byte   (in_tdata),
    .in_last   (in_tlast),
    .push      (push),
    .job       (push_job)
  );

  b64sc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .pop       (pop),
    .head_job  (head_job),
    .not_empty (q_valid),
    .full      (q_full)
  );

  b64sc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_job   (head_job),
    .head_valid (q_valid),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_byte   (out_tdata),
    .out_last   (out_tlast),
    .out_status (out_tuser)
  );

  `B64SC_ASSERT_SAME(a_no_push_when_full, push, !q_full, "push into a full queue")
  `B64SC_ASSERT_NEXT(a_drain_idle, out_tvalid && out_tready && out_tlast && !q_valid,
                     !out_tvalid, "output still valid after its last result")
  `B64SC_ASSERT_NEXT(a_back_loads, q_valid && !out_tvalid, out_tvalid,
                     "queued item not taken by an idle back end")

endmodule

`default_nettype wire

// ----- tb/base64_stream_codec_unit_test.sv -----
`timescale 1ns / 100ps

module base64_stream_codec_unit_test;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic [1:0] status;
  } codec_result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_data = b64sc_pkg::DIR_ENCODE;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;  // [7:0] in_byte
  logic       in_tlast = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;         // [7:0] out_byte
  logic       out_tlast;
  logic [1:0] out_tuser;         // [1:0] status

  int in_idle_pct = 0;
  int out_stall_pct = 0;
  int error_count = 0;

  logic        codec_dir = b64sc_pkg::DIR_ENCODE;
  logic [23:0] group_bits = '0;
  logic [1:0]  group_count = '0;
  logic        pad_seen = 1'b0;
  logic        bad_char_seen = 1'b0;

  codec_result_t expected_chars[$];

  base64_stream_codec_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    out_tready <= (int'($urandom_range(99)) >= out_stall_pct);
  end

  function automatic logic [7:0] sextet_to_ascii(input logic [5:0] v);
    logic [7:0] wide;
    wide = {2'b00, v};
    case (1'b1)
      (v <= 6'd25): return wide + 8'd65;
      (v <= 6'd51): return wide + 8'd71;
      (v <= 6'd61): return wide - 8'd4;
      (v == 6'd62): return 8'h2B;
      default:      return 8'h2F;
    endcase
  endfunction

  // Bit 6 set means the character is outside the alphabet.
  function automatic logic [6:0] ascii_to_sextet(input logic [7:0] c);
    logic [7:0] r;
    r = 8'd64;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c - 8'd65;
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r = c - 8'd71;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r = c + 8'd4;
    end else if (c == 8'h2B) begin
      r = 8'd62;
    end else if (c == 8'h2F) begin
      r = 8'd63;
    end
    return r[6:0];
  endfunction

  function automatic codec_result_t make_result(input logic [7:0] data,
                                                input logic [1:0] status);
    codec_result_t r;
    r.data = data;
    r.last = 1'b0;
    r.status = status;
    return r;
  endfunction

  task automatic predict_codec_step(input logic [7:0] b, input logic last);
    int          first_idx;
    logic [23:0] v;
    logic [6:0]  idx;
    logic [1:0]  pos;
    logic [1:0]  st;
    logic        bad_len;
    codec_result_t tail;
    first_idx = expected_chars.size();
    if (codec_dir == b64sc_pkg::DIR_ENCODE) begin
      group_bits = {group_bits[15:0], b};
      group_count = group_count + 2'd1;
      if (group_count == 2'd3) begin
        for (int k = 3; k >= 0; k--) begin
          expected_chars.push_back(make_result(sextet_to_ascii(group_bits[6*k +: 6]),
                                               b64sc_pkg::STATUS_OK));
        end
        group_bits = '0;
        group_count = '0;
      end
      if (last && group_count != 2'd0) begin
        v = (group_count == 2'd1) ? {group_bits[7:0], 16'h0} : {group_bits[15:0], 8'h0};
        expected_chars.push_back(make_result(sextet_to_ascii(v[23:18]),
                                             b64sc_pkg::STATUS_OK));
        expected_chars.push_back(make_result(sextet_to_ascii(v[17:12]),
                                             b64sc_pkg::STATUS_OK));
        expected_chars.push_back(make_result(
          (group_count == 2'd2) ? sextet_to_ascii(v[11:6]) : b64sc_pkg::PAD_CHAR,
          b64sc_pkg::STATUS_OK));
        expected_chars.push_back(make_result(b64sc_pkg::PAD_CHAR, b64sc_pkg::STATUS_OK));
      end
    end else begin
      pos = group_count;
      bad_len = last && (pos != 2'd3);
      if (!pad_seen) begin
        if (b == b64sc_pkg::PAD_CHAR && pos >= 2'd2) begin
          pad_seen = 1'b1;
          st = bad_len ? b64sc_pkg::STATUS_BAD_LEN
                       : (bad_char_seen ? b64sc_pkg::STATUS_INVALID : b64sc_pkg::STATUS_OK);
          if (pos == 2'd2) begin
            v = {group_bits[11:0], 12'h0};
            expected_chars.push_back(make_result(v[23:16], st));
          end else begin
            v = {group_bits[17:0], 6'h0};
            expected_chars.push_back(make_result(v[23:16], st));
            expected_chars.push_back(make_result(v[15:8], st));
          end
          group_bits = '0;
        end else begin
          idx = ascii_to_sextet(b);
          if (idx[6]) begin
            idx = 7'd63;
            bad_char_seen = 1'b1;
          end
          group_bits = {group_bits[17:0], idx[5:0]};
          if (pos == 2'd3) begin
            st = bad_char_seen ? b64sc_pkg::STATUS_INVALID : b64sc_pkg::STATUS_OK;
            expected_chars.push_back(make_result(group_bits[23:16], st));
            expected_chars.push_back(make_result(group_bits[15:8], st));
            expected_chars.push_back(make_result(group_bits[7:0], st));
            group_bits = '0;
          end
        end
      end
      group_count = pos + 2'd1;
      if (last && expected_chars.size() == first_idx && (bad_len || bad_char_seen)) begin
        expected_chars.push_back(make_result(8'h00, bad_len ? b64sc_pkg::STATUS_BAD_LEN
                                                            : b64sc_pkg::STATUS_INVALID));
      end
    end
    if (last) begin
      group_bits = '0;
      group_count = '0;
      pad_seen = 1'b0;
      bad_char_seen = 1'b0;
    end
    if (expected_chars.size() > first_idx) begin
      tail = expected_chars.pop_back();
      tail.last = 1'b1;
      expected_chars.push_back(tail);
    end
  endtask

  always @(posedge clk) begin : result_check
    codec_result_t exp_r;
    if (!rst && out_tvalid && out_tready) begin
      if (expected_chars.size() == 0) begin
        $error("unexpected item: out_byte %02h", out_tdata);
        error_count++;
      end else begin
        exp_r = expected_chars.pop_front();
        if (out_tdata !== exp_r.data) begin
          $error("out_byte: expected %02h, got %02h", exp_r.data, out_tdata);
          error_count++;
        end
        if (out_tlast !== exp_r.last) begin
          $error("out_last: expected %0b, got %0b", exp_r.last, out_tlast);
          error_count++;
        end
        if (out_tuser !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, out_tuser);
          error_count++;
        end
      end
    end
  end

  task automatic send_item(input logic [7:0] b, input logic last);
    while (int'($urandom_range(99)) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    predict_codec_step(b, last);
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_item(s[i], i == s.len() - 1);
    end
  endtask

  task automatic send_stream(input logic [7:0] stream[$]);
    for (int i = 0; i < stream.size(); i++) begin
      send_item(stream[i], i == stream.size() - 1);
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_direction(input logic dir);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= dir;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    codec_dir = dir;
    group_bits = '0;
    group_count = '0;
    pad_seen = 1'b0;
    bad_char_seen = 1'b0;
  endtask

  task automatic test_encode_directed();
    send_item(8'h00, 1'b1);
    send_item(8'hFF, 1'b0);
    send_item(8'h80, 1'b1);
    send_item(8'hFF, 1'b0);
    send_item(8'h7F, 1'b0);
    send_item(8'h01, 1'b1);
    wait_drained();
  endtask

  // A direction write drops the two bytes gathered before it.
  task automatic test_direction_write_clears();
    send_item(8'hAB, 1'b0);
    send_item(8'hCD, 1'b0);
    write_direction(b64sc_pkg::DIR_ENCODE);
    send_item(8'hEF, 1'b1);
    wait_drained();
  endtask

  task automatic test_decode_directed();
    write_direction(b64sc_pkg::DIR_DECODE);
    send_text("=Az/");
    send_text("+/9=");
    send_text("TQ=");
    send_text("*A==");
    send_text("aZ==0");
    wait_drained();
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                     input logic dir, input int n_items);
    logic [7:0] stream[$];
    int         sent;
    int         len;
    int         n_pad;
    int         pick;
    write_direction(dir);
    in_idle_pct = idle_pct;
    out_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_items) begin
      stream.delete();
      if (dir == b64sc_pkg::DIR_ENCODE) begin
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++) stream.push_back(8'($urandom_range(255)));
      end else if ($urandom_range(9) < 8) begin
        len = 4 * $urandom_range(1, 3);
        n_pad = $urandom_range(2);
        for (int i = 0; i < len; i++) begin
          if (i >= len - n_pad) stream.push_back(b64sc_pkg::PAD_CHAR);
          else stream.push_back(sextet_to_ascii(6'($urandom_range(63))));
        end
      end else begin
        len = $urandom_range(1, 9);
        for (int i = 0; i < len; i++) begin
          pick = $urandom_range(9);
          if (pick < 6) stream.push_back(sextet_to_ascii(6'($urandom_range(63))));
          else if (pick < 8) stream.push_back(b64sc_pkg::PAD_CHAR);
          else stream.push_back(8'($urandom_range(255)));
        end
      end
      send_stream(stream);
      sent += stream.size();
    end
    wait_drained();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_encode_directed();
    test_direction_write_clears();
    test_decode_directed();
    test_random_traffic(0, 0, b64sc_pkg::DIR_ENCODE, 20);
    test_random_traffic(0, 0, b64sc_pkg::DIR_DECODE, 20);
    test_random_traffic(84, 0, b64sc_pkg::DIR_ENCODE, 20);
    test_random_traffic(84, 0, b64sc_pkg::DIR_DECODE, 20);
    test_random_traffic(0, 84, b64sc_pkg::DIR_DECODE, 20);
    test_random_traffic(0, 84, b64sc_pkg::DIR_ENCODE, 20);
    test_random_traffic(27, 27, b64sc_pkg::DIR_DECODE, 20);
    test_random_traffic(27, 27, b64sc_pkg::DIR_ENCODE, 20);
    wait_drained();
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule
